>>> hdl/tvfp_pkg.sv
// shared types, codes and the solver micro-program for the two-view focal pair block
// no dependencies; imported by every module of the block
`default_nettype none

package tvfp_pkg;

    localparam int PC_W    = 7;
    localparam int NUM_SRC = 37;

    // operand and destination selects of the back-end register set
    typedef enum logic [5:0] {
        SRC_ZERO, SRC_E00, SRC_E01, SRC_E02, SRC_E10, SRC_E11, SRC_E12, SRC_E20, SRC_E21,
        SRC_E22, SRC_U0, SRC_V0, SRC_U1, SRC_V1, SRC_P0, SRC_Q0, SRC_P1, SRC_Q1,
        SRC_T0, SRC_T1, SRC_H0, SRC_H1, SRC_K0, SRC_K1, SRC_S0, SRC_S1, SRC_G, SRC_D,
        SRC_DS, SRC_A, SRC_B, SRC_C, SRC_R, SRC_X1, SRC_X2, SRC_Y, SRC_F1
    } src_t;

    typedef enum logic [3:0] {
        OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUB, OP_NEGD,
        OP_BRZ, OP_BRN, OP_BRLE, OP_JMP, OP_EMIT, OP_END
    } op_t;

    typedef enum logic [1:0] {
        ALU_MUL, ALU_DIV, ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        op_t             op;
        src_t            dst;
        src_t            sa;
        src_t            sb;
        logic [PC_W-1:0] tgt;
    } instr_t;

    typedef struct packed {
        logic [31:0] e00;
        logic [31:0] e01;
        logic [31:0] e02;
        logic [31:0] e10;
        logic [31:0] e11;
        logic [31:0] e12;
        logic [31:0] e20;
        logic [31:0] e21;
        logic [31:0] e22;
    } ess_t;

    // configuration register indexes
    localparam logic [2:0] CFG_E00_E01 = 3'd0;
    localparam logic [2:0] CFG_E02_E10 = 3'd1;
    localparam logic [2:0] CFG_E11_E12 = 3'd2;
    localparam logic [2:0] CFG_E20_E21 = 3'd3;
    localparam logic [2:0] CFG_E22     = 3'd4;

    localparam logic [PC_W-1:0] PC_NONE = 7'd0;
    localparam logic [PC_W-1:0] PC_SKIP1 = 7'd72;
    localparam logic [PC_W-1:0] PC_CAND2 = 7'd73;
    localparam logic [PC_W-1:0] PC_FIN  = 7'd79;
    localparam logic [PC_W-1:0] PC_LIN  = 7'd80;
    localparam logic [PC_W-1:0] PC_ORD  = 7'd65;

    function automatic instr_t mk(op_t op, src_t dst, src_t sa, src_t sb,
                                  logic [PC_W-1:0] tgt);
        instr_t i;
        i.op  = op;
        i.dst = dst;
        i.sa  = sa;
        i.sb  = sb;
        i.tgt = tgt;
        return i;
    endfunction

    // solver program: h, k, s terms, quadratic coefficients, roots, first focal
    function automatic instr_t prog(logic [PC_W-1:0] pc);
        instr_t i;
        case (pc)
            7'd0:  i = mk(OP_MUL, SRC_T0, SRC_E20, SRC_U0, PC_NONE);
            7'd1:  i = mk(OP_MUL, SRC_T1, SRC_E21, SRC_V0, PC_NONE);
            7'd2:  i = mk(OP_ADD, SRC_H0, SRC_T0, SRC_T1, PC_NONE);
            7'd3:  i = mk(OP_MUL, SRC_T0, SRC_E20, SRC_U1, PC_NONE);
            7'd4:  i = mk(OP_MUL, SRC_T1, SRC_E21, SRC_V1, PC_NONE);
            7'd5:  i = mk(OP_ADD, SRC_H1, SRC_T0, SRC_T1, PC_NONE);
            7'd6:  i = mk(OP_MUL, SRC_T0, SRC_E02, SRC_P0, PC_NONE);
            7'd7:  i = mk(OP_MUL, SRC_T1, SRC_E12, SRC_Q0, PC_NONE);
            7'd8:  i = mk(OP_ADD, SRC_K0, SRC_T0, SRC_T1, PC_NONE);
            7'd9:  i = mk(OP_MUL, SRC_T0, SRC_E02, SRC_P1, PC_NONE);
            7'd10: i = mk(OP_MUL, SRC_T1, SRC_E12, SRC_Q1, PC_NONE);
            7'd11: i = mk(OP_ADD, SRC_K1, SRC_T0, SRC_T1, PC_NONE);
            7'd12: i = mk(OP_SUB, SRC_D, SRC_K0, SRC_K1, PC_NONE);
            7'd13: i = mk(OP_BRZ, SRC_ZERO, SRC_D, SRC_ZERO, PC_FIN);
            7'd14: i = mk(OP_MUL, SRC_T0, SRC_E00, SRC_U0, PC_NONE);
            7'd15: i = mk(OP_MUL, SRC_T0, SRC_T0, SRC_P0, PC_NONE);
            7'd16: i = mk(OP_MUL, SRC_T1, SRC_E01, SRC_V0, PC_NONE);
            7'd17: i = mk(OP_MUL, SRC_T1, SRC_T1, SRC_P0, PC_NONE);
            7'd18: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_T1, PC_NONE);
            7'd19: i = mk(OP_MUL, SRC_T1, SRC_E10, SRC_U0, PC_NONE);
            7'd20: i = mk(OP_MUL, SRC_T1, SRC_T1, SRC_Q0, PC_NONE);
            7'd21: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_T1, PC_NONE);
            7'd22: i = mk(OP_MUL, SRC_T1, SRC_E11, SRC_V0, PC_NONE);
            7'd23: i = mk(OP_MUL, SRC_T1, SRC_T1, SRC_Q0, PC_NONE);
            7'd24: i = mk(OP_ADD, SRC_S0, SRC_T0, SRC_T1, PC_NONE);
            7'd25: i = mk(OP_MUL, SRC_T0, SRC_E00, SRC_U1, PC_NONE);
            7'd26: i = mk(OP_MUL, SRC_T0, SRC_T0, SRC_P1, PC_NONE);
            7'd27: i = mk(OP_MUL, SRC_T1, SRC_E01, SRC_V1, PC_NONE);
            7'd28: i = mk(OP_MUL, SRC_T1, SRC_T1, SRC_P1, PC_NONE);
            7'd29: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_T1, PC_NONE);
            7'd30: i = mk(OP_MUL, SRC_T1, SRC_E10, SRC_U1, PC_NONE);
            7'd31: i = mk(OP_MUL, SRC_T1, SRC_T1, SRC_Q1, PC_NONE);
            7'd32: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_T1, PC_NONE);
            7'd33: i = mk(OP_MUL, SRC_T1, SRC_E11, SRC_V1, PC_NONE);
            7'd34: i = mk(OP_MUL, SRC_T1, SRC_T1, SRC_Q1, PC_NONE);
            7'd35: i = mk(OP_ADD, SRC_S1, SRC_T0, SRC_T1, PC_NONE);
            7'd36: i = mk(OP_SUB, SRC_G, SRC_H1, SRC_H0, PC_NONE);
            7'd37: i = mk(OP_SUB, SRC_DS, SRC_S1, SRC_S0, PC_NONE);
            7'd38: i = mk(OP_MUL, SRC_A, SRC_G, SRC_E22, PC_NONE);
            7'd39: i = mk(OP_MUL, SRC_T0, SRC_DS, SRC_E22, PC_NONE);
            7'd40: i = mk(OP_MUL, SRC_T1, SRC_H1, SRC_K0, PC_NONE);
            7'd41: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_T1, PC_NONE);
            7'd42: i = mk(OP_MUL, SRC_T1, SRC_H0, SRC_K1, PC_NONE);
            7'd43: i = mk(OP_SUB, SRC_B, SRC_T0, SRC_T1, PC_NONE);
            7'd44: i = mk(OP_MUL, SRC_T0, SRC_S1, SRC_K0, PC_NONE);
            7'd45: i = mk(OP_MUL, SRC_T1, SRC_S0, SRC_K1, PC_NONE);
            7'd46: i = mk(OP_SUB, SRC_C, SRC_T0, SRC_T1, PC_NONE);
            7'd47: i = mk(OP_NEGD, SRC_A, SRC_A, SRC_ZERO, PC_NONE);
            7'd48: i = mk(OP_NEGD, SRC_B, SRC_B, SRC_ZERO, PC_NONE);
            7'd49: i = mk(OP_NEGD, SRC_C, SRC_C, SRC_ZERO, PC_NONE);
            7'd50: i = mk(OP_MUL, SRC_T0, SRC_B, SRC_B, PC_NONE);
            7'd51: i = mk(OP_MUL, SRC_T1, SRC_C, SRC_A, PC_NONE);
            7'd52: i = mk(OP_ADD, SRC_T1, SRC_T1, SRC_T1, PC_NONE);
            7'd53: i = mk(OP_ADD, SRC_T1, SRC_T1, SRC_T1, PC_NONE);
            7'd54: i = mk(OP_SUB, SRC_T0, SRC_T0, SRC_T1, PC_NONE);
            7'd55: i = mk(OP_BRN, SRC_ZERO, SRC_T0, SRC_ZERO, PC_FIN);
            7'd56: i = mk(OP_BRZ, SRC_ZERO, SRC_A, SRC_ZERO, PC_LIN);
            7'd57: i = mk(OP_SQRT, SRC_R, SRC_T0, SRC_ZERO, PC_NONE);
            7'd58: i = mk(OP_SUB, SRC_T1, SRC_ZERO, SRC_B, PC_NONE);
            7'd59: i = mk(OP_ADD, SRC_A, SRC_A, SRC_A, PC_NONE);
            7'd60: i = mk(OP_SUB, SRC_X1, SRC_T1, SRC_R, PC_NONE);
            7'd61: i = mk(OP_ADD, SRC_X2, SRC_T1, SRC_R, PC_NONE);
            7'd62: i = mk(OP_BRLE, SRC_ZERO, SRC_B, SRC_ZERO, PC_ORD);
            7'd63: i = mk(OP_ADD, SRC_X1, SRC_T1, SRC_R, PC_NONE);
            7'd64: i = mk(OP_SUB, SRC_X2, SRC_T1, SRC_R, PC_NONE);
            7'd65: i = mk(OP_DIV, SRC_Y, SRC_X1, SRC_A, PC_NONE);
            7'd66: i = mk(OP_BRN, SRC_ZERO, SRC_Y, SRC_ZERO, PC_SKIP1);
            7'd67: i = mk(OP_MUL, SRC_T0, SRC_Y, SRC_G, PC_NONE);
            7'd68: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_DS, PC_NONE);
            7'd69: i = mk(OP_DIV, SRC_F1, SRC_T0, SRC_D, PC_NONE);
            7'd70: i = mk(OP_BRN, SRC_ZERO, SRC_F1, SRC_ZERO, PC_SKIP1);
            7'd71: i = mk(OP_EMIT, SRC_ZERO, SRC_ZERO, SRC_ZERO, PC_NONE);
            7'd72: i = mk(OP_DIV, SRC_Y, SRC_X2, SRC_A, PC_NONE);
            7'd73: i = mk(OP_BRN, SRC_ZERO, SRC_Y, SRC_ZERO, PC_FIN);
            7'd74: i = mk(OP_MUL, SRC_T0, SRC_Y, SRC_G, PC_NONE);
            7'd75: i = mk(OP_ADD, SRC_T0, SRC_T0, SRC_DS, PC_NONE);
            7'd76: i = mk(OP_DIV, SRC_F1, SRC_T0, SRC_D, PC_NONE);
            7'd77: i = mk(OP_BRN, SRC_ZERO, SRC_F1, SRC_ZERO, PC_FIN);
            7'd78: i = mk(OP_EMIT, SRC_ZERO, SRC_ZERO, SRC_ZERO, PC_NONE);
            7'd79: i = mk(OP_END, SRC_ZERO, SRC_ZERO, SRC_ZERO, PC_NONE);
            7'd80: i = mk(OP_BRZ, SRC_ZERO, SRC_B, SRC_ZERO, PC_FIN);
            7'd81: i = mk(OP_SUB, SRC_T0, SRC_ZERO, SRC_C, PC_NONE);
            7'd82: i = mk(OP_DIV, SRC_Y, SRC_T0, SRC_B, PC_NONE);
            7'd83: i = mk(OP_JMP, SRC_ZERO, SRC_ZERO, SRC_ZERO, PC_CAND2);
            default: i = mk(OP_END, SRC_ZERO, SRC_ZERO, SRC_ZERO, PC_NONE);
        endcase
        return i;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tvfp_front.sv
// front end: accepts correspondence transactions into a two-entry queue
// depends on tvfp_pkg
`default_nettype none

module tvfp_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [8*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                          item_valid,
    input  wire logic                     item_ready,
    output logic [8*COORD_WIDTH-1:0]      item_data
);
    import tvfp_pkg::*;

    logic [8*COORD_WIDTH-1:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign s_axis_tready = (count_reg != 2'd2);
    assign item_valid    = (count_reg != 2'd0);
    assign item_data     = slot_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= s_axis_tdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tvfp_alu.sv
// shared bit-serial unit: signed multiply, floor divide, integer square root
// depends on tvfp_pkg
`default_nettype none

module tvfp_alu #(
    parameter int XW = 272
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tvfp_pkg::alu_cmd_t cmd,
    input  wire logic [XW-1:0]      a,
    input  wire logic [XW-1:0]      b,
    output logic                    done,
    output logic [XW-1:0]           result
);
    import tvfp_pkg::*;

    localparam int CW = $clog2(XW + 1);

    // acc: product / remainder / root; mc: multiplicand / dividend / radicand
    // ml: multiplier / quotient / root bit; den: divisor
    logic          busy_reg, busy_next;
    alu_op_t       op_reg, op_next;
    logic          neg_reg, neg_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [XW-1:0] mc_reg, mc_next;
    logic [XW-1:0] ml_reg, ml_next;
    logic [XW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [XW-1:0] result_reg, result_next;

    logic [XW-1:0] a_mag, b_mag, rem2, qn, sq_t, sq_sh, accn;

    assign a_mag  = a[XW-1] ? (~a + 1'b1) : a;
    assign b_mag  = b[XW-1] ? (~b + 1'b1) : b;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        op_next     = op_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        mc_next     = mc_reg;
        ml_next     = ml_reg;
        den_next    = den_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rem2        = {acc_reg[XW-2:0], mc_reg[XW-1]};
        qn          = {ml_reg[XW-2:0], 1'b0};
        sq_t        = acc_reg + ml_reg;
        sq_sh       = acc_reg >> 1;
        accn        = acc_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            neg_next  = a[XW-1] ^ b[XW-1];
            acc_next  = '0;
            den_next  = b_mag;
            unique case (cmd.op)
                ALU_MUL:
                begin
                    mc_next = a_mag;
                    ml_next = b_mag;
                    cnt_next = '0;
                end
                ALU_DIV:
                begin
                    mc_next  = a_mag;
                    ml_next  = '0;
                    cnt_next = CW'(XW);
                end
                ALU_SQRT:
                begin
                    mc_next  = a;
                    ml_next  = {2'b01, {(XW-2){1'b0}}};
                    cnt_next = CW'(XW / 2);
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (ml_reg == '0)
                    begin
                        busy_next   = 1'b0;
                        done_next   = 1'b1;
                        result_next = neg_reg ? (~acc_reg + 1'b1) : acc_reg;
                    end
                    else
                    begin
                        acc_next = acc_reg + (ml_reg[0] ? mc_reg : '0);
                        mc_next  = mc_reg << 1;
                        ml_next  = ml_reg >> 1;
                    end
                end
                ALU_DIV:
                begin
                    // restoring step, one quotient bit
                    mc_next = mc_reg << 1;
                    if (rem2 >= den_reg)
                    begin
                        accn = rem2 - den_reg;
                        qn   = {ml_reg[XW-2:0], 1'b1};
                    end
                    else
                    begin
                        accn = rem2;
                    end
                    acc_next = accn;
                    ml_next  = qn;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        // floor: -q, or -q-1 when a remainder is left
                        if (neg_reg)
                            result_next = (accn != '0) ? ~qn : (~qn + 1'b1);
                        else
                            result_next = qn;
                    end
                end
                ALU_SQRT:
                begin
                    if (mc_reg >= sq_t)
                    begin
                        mc_next = mc_reg - sq_t;
                        accn    = sq_sh + ml_reg;
                    end
                    else
                    begin
                        accn = sq_sh;
                    end
                    acc_next = accn;
                    ml_next  = ml_reg >> 2;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        busy_next   = 1'b0;
                        done_next   = 1'b1;
                        result_next = accn;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        mc_reg     <= mc_next;
        ml_reg     <= ml_next;
        den_reg    <= den_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

>>> hdl/tvfp_back.sv
// back end: micro-programmed sequencer over wide registers, result register
// depends on tvfp_pkg and tvfp_alu
`default_nettype none

module tvfp_back #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tvfp_pkg::ess_t           ess,
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire logic [8*COORD_WIDTH-1:0] item_data,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [63:0]                   m_axis_tdata,
    output logic                          m_axis_tlast
);
    import tvfp_pkg::*;

    localparam int XW = 4 * COORD_WIDTH + 144;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_ALU  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     pend_f1_reg, pend_f2_reg;
    logic [63:0]     out_data_reg;
    logic            out_last_reg;

    logic signed [COORD_WIDTH-1:0] u0_reg, v0_reg, u1_reg, v1_reg;
    logic signed [COORD_WIDTH-1:0] p0_reg, q0_reg, p1_reg, q1_reg;
    logic [XW-1:0] t0_reg, t1_reg, h0_reg, h1_reg, k0_reg, k1_reg, s0_reg, s1_reg;
    logic [XW-1:0] g_reg, d_reg, ds_reg, a_reg, b_reg, c_reg, r_reg;
    logic [XW-1:0] x1_reg, x2_reg, y_reg, f1_reg;

    logic [XW-1:0] src_val [NUM_SRC];
    logic [XW-1:0] opa, opb, wr_data, alu_result;
    logic          wr_en, load_item, out_free, out_load, out_last, pend_load, alu_done;
    logic [63:0]   out_data;
    alu_cmd_t      alu_cmd;
    instr_t        ins;

    function automatic logic [XW-1:0] ext32(logic [31:0] v);
        return {{(XW-32){v[31]}}, v};
    endfunction

    function automatic logic [XW-1:0] extc(logic [COORD_WIDTH-1:0] v);
        return {{(XW-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

    function automatic logic [31:0] sat32(logic [XW-1:0] v);
        return (|v[XW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    assign ins = prog(pc_reg);

    always_comb
    begin
        src_val[SRC_ZERO] = '0;
        src_val[SRC_E00]  = ext32(ess.e00);
        src_val[SRC_E01]  = ext32(ess.e01);
        src_val[SRC_E02]  = ext32(ess.e02);
        src_val[SRC_E10]  = ext32(ess.e10);
        src_val[SRC_E11]  = ext32(ess.e11);
        src_val[SRC_E12]  = ext32(ess.e12);
        src_val[SRC_E20]  = ext32(ess.e20);
        src_val[SRC_E21]  = ext32(ess.e21);
        src_val[SRC_E22]  = ext32(ess.e22);
        src_val[SRC_U0]   = extc(u0_reg);
        src_val[SRC_V0]   = extc(v0_reg);
        src_val[SRC_U1]   = extc(u1_reg);
        src_val[SRC_V1]   = extc(v1_reg);
        src_val[SRC_P0]   = extc(p0_reg);
        src_val[SRC_Q0]   = extc(q0_reg);
        src_val[SRC_P1]   = extc(p1_reg);
        src_val[SRC_Q1]   = extc(q1_reg);
        src_val[SRC_T0]   = t0_reg;
        src_val[SRC_T1]   = t1_reg;
        src_val[SRC_H0]   = h0_reg;
        src_val[SRC_H1]   = h1_reg;
        src_val[SRC_K0]   = k0_reg;
        src_val[SRC_K1]   = k1_reg;
        src_val[SRC_S0]   = s0_reg;
        src_val[SRC_S1]   = s1_reg;
        src_val[SRC_G]    = g_reg;
        src_val[SRC_D]    = d_reg;
        src_val[SRC_DS]   = ds_reg;
        src_val[SRC_A]    = a_reg;
        src_val[SRC_B]    = b_reg;
        src_val[SRC_C]    = c_reg;
        src_val[SRC_R]    = r_reg;
        src_val[SRC_X1]   = x1_reg;
        src_val[SRC_X2]   = x2_reg;
        src_val[SRC_Y]    = y_reg;
        src_val[SRC_F1]   = f1_reg;
    end

    assign opa      = src_val[ins.sa];
    assign opb      = src_val[ins.sb];
    assign out_free = !out_valid_reg || m_axis_tready;

    tvfp_alu #(
        .XW (XW)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .a      (opa),
        .b      (opb),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        pend_valid_next = pend_valid_reg;
        wr_en           = 1'b0;
        wr_data         = '0;
        alu_cmd.start   = 1'b0;
        alu_cmd.op      = ALU_MUL;
        item_ready      = 1'b0;
        load_item       = 1'b0;
        out_load        = 1'b0;
        out_last        = 1'b0;
        out_data        = {pend_f2_reg, pend_f1_reg};
        pend_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    load_item  = 1'b1;
                    pc_next    = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unique case (ins.op)
                    OP_ADD:
                    begin
                        wr_en   = 1'b1;
                        wr_data = opa + opb;
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_SUB:
                    begin
                        wr_en   = 1'b1;
                        wr_data = opa - opb;
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_NEGD:
                    begin
                        wr_en   = 1'b1;
                        wr_data = d_reg[XW-1] ? (~opa + 1'b1) : opa;
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_MUL:
                    begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ALU_MUL;
                        state_next    = ST_ALU;
                    end
                    OP_DIV:
                    begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ALU_DIV;
                        state_next    = ST_ALU;
                    end
                    OP_SQRT:
                    begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ALU_SQRT;
                        state_next    = ST_ALU;
                    end
                    OP_BRZ:
                        pc_next = (opa == '0) ? ins.tgt : pc_reg + 1'b1;
                    OP_BRN:
                        pc_next = opa[XW-1] ? ins.tgt : pc_reg + 1'b1;
                    OP_BRLE:
                        pc_next = (opa[XW-1] || opa == '0) ? ins.tgt : pc_reg + 1'b1;
                    OP_JMP:
                        pc_next = ins.tgt;
                    OP_EMIT:
                    begin
                        // a held solution goes out once a newer one exists, or at the end marked last
                        if (!pend_valid_reg || out_free)
                        begin
                            out_load        = pend_valid_reg;
                            pend_load       = 1'b1;
                            pend_valid_next = 1'b1;
                            pc_next         = pc_reg + 1'b1;
                        end
                    end
                    OP_END:
                    begin
                        if (!pend_valid_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            out_load        = 1'b1;
                            out_last        = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_ALU:
            begin
                if (alu_done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = alu_result;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            u0_reg <= item_data[0*COORD_WIDTH +: COORD_WIDTH];
            v0_reg <= item_data[1*COORD_WIDTH +: COORD_WIDTH];
            u1_reg <= item_data[2*COORD_WIDTH +: COORD_WIDTH];
            v1_reg <= item_data[3*COORD_WIDTH +: COORD_WIDTH];
            p0_reg <= item_data[4*COORD_WIDTH +: COORD_WIDTH];
            q0_reg <= item_data[5*COORD_WIDTH +: COORD_WIDTH];
            p1_reg <= item_data[6*COORD_WIDTH +: COORD_WIDTH];
            q1_reg <= item_data[7*COORD_WIDTH +: COORD_WIDTH];
        end
        if (pend_load)
        begin
            pend_f1_reg <= sat32(f1_reg);
            pend_f2_reg <= sat32(y_reg);
        end
        if (out_load)
        begin
            out_data_reg <= out_data;
            out_last_reg <= out_last;
        end
        if (wr_en)
        begin
            case (ins.dst)
                SRC_T0:  t0_reg <= wr_data;
                SRC_T1:  t1_reg <= wr_data;
                SRC_H0:  h0_reg <= wr_data;
                SRC_H1:  h1_reg <= wr_data;
                SRC_K0:  k0_reg <= wr_data;
                SRC_K1:  k1_reg <= wr_data;
                SRC_S0:  s0_reg <= wr_data;
                SRC_S1:  s1_reg <= wr_data;
                SRC_G:   g_reg  <= wr_data;
                SRC_D:   d_reg  <= wr_data;
                SRC_DS:  ds_reg <= wr_data;
                SRC_A:   a_reg  <= wr_data;
                SRC_B:   b_reg  <= wr_data;
                SRC_C:   c_reg  <= wr_data;
                SRC_R:   r_reg  <= wr_data;
                SRC_X1:  x1_reg <= wr_data;
                SRC_X2:  x2_reg <= wr_data;
                SRC_Y:   y_reg  <= wr_data;
                SRC_F1:  f1_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> hdl/two_view_focal_pair_quadratic.sv
// top level of the two-view focal pair solver with a configured essential matrix
// depends on tvfp_pkg, tvfp_front, tvfp_back (and tvfp_alu below it)
`default_nettype none

// Solves for camera focal pairs from two point correspondences and an essential
// matrix held in five configuration registers. Each input transaction carries the
// two points of view 1 and view 2; the block forms the quadratic in the second
// focal exactly in wide integers, takes its real roots (floor rounding), derives
// the first focal linearly and emits zero, one or two pairs, the last marked by
// tlast. Negative candidates are dropped and outputs saturate to 0xFFFFFFFF.
// The work of an item runs through one shared bit-serial unit, one bit per cycle,
// where a multiply steps through the significant bits of the second operand, a
// divide through 4*COORD_WIDTH+144 quotient bits and the square root through half
// as many root bits; the other program steps run in the sequencer itself. An item
// can also wait on the result side.
// A two-entry input queue accepts new transactions while an item is in work, and
// the result register lets the sequencer go on while a result waits on the output
// side. Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this, and cfg_ready is always high.

module two_view_focal_pair_quadratic #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input transaction
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // view1_pt0_x, view1_pt0_y, view1_pt1_x, view1_pt1_y,
    // view2_pt0_x, view2_pt0_y, view2_pt1_x, view2_pt1_y
    input  wire logic [8*COORD_WIDTH-1:0] s_axis_tdata,
    // result transaction
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // first_focal [31:0], second_focal [63:32]
    output logic [63:0]                   m_axis_tdata,
    // last_solution
    output logic                          m_axis_tlast,
    // register writes
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [2:0]               cfg_addr,
    input  wire logic [63:0]              cfg_data
);
    import tvfp_pkg::*;

    logic [63:0] e00_e01_reg;
    logic [63:0] e02_e10_reg;
    logic [63:0] e11_e12_reg;
    logic [63:0] e20_e21_reg;
    logic [31:0] e22_reg;

    ess_t                     ess;
    logic                     item_valid, item_ready;
    logic [8*COORD_WIDTH-1:0] item_data;

    assign cfg_ready = 1'b1;

    // register file, packed pairs hold the first-named entry in bits 63..32
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e00_e01_reg <= '0;
            e02_e10_reg <= '0;
            e11_e12_reg <= '0;
            e20_e21_reg <= '0;
            e22_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_E00_E01: e00_e01_reg <= cfg_data;
                CFG_E02_E10: e02_e10_reg <= cfg_data;
                CFG_E11_E12: e11_e12_reg <= cfg_data;
                CFG_E20_E21: e20_e21_reg <= cfg_data;
                CFG_E22:     e22_reg     <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        ess.e00 = e00_e01_reg[63:32];
        ess.e01 = e00_e01_reg[31:0];
        ess.e02 = e02_e10_reg[63:32];
        ess.e10 = e02_e10_reg[31:0];
        ess.e11 = e11_e12_reg[63:32];
        ess.e12 = e11_e12_reg[31:0];
        ess.e20 = e20_e21_reg[63:32];
        ess.e21 = e20_e21_reg[31:0];
        ess.e22 = e22_reg;
    end

    // front: input queue
    tvfp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item_data     (item_data)
    );

    // back: solver sequencer and result register
    tvfp_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ess           (ess),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item_data     (item_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
